// File: src/lbrq_pkg.sv
package lbrq_pkg;

  // Default sizes of the ring
  localparam int QUEUE_BYTES_DEF  = 1024;
  localparam int HEADER_BYTES_DEF = 4;
  localparam int MAX_READ_DEF     = 64;

  // Fixed field widths
  localparam int OP_W   = 3;
  localparam int LEN_W  = 10;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 3;
  localparam int FREE_W = 11;

  // Operation codes on the input port
  localparam logic [OP_W-1:0] OPC_START = 3'd0;
  localparam logic [OP_W-1:0] OPC_PUSH  = 3'd1;
  localparam logic [OP_W-1:0] OPC_POP   = 3'd2;
  localparam logic [OP_W-1:0] OPC_PEEK  = 3'd3;
  localparam logic [OP_W-1:0] OPC_CLEAR = 3'd4;

  // Status codes on the result port
  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd2;
  localparam logic [STAT_W-1:0] ST_OPEN   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_REC = 3'd4;

  // Decoded command kind
  typedef enum logic [2:0] {
    K_START = 3'd0,
    K_PUSH  = 3'd1,
    K_POP   = 3'd2,
    K_PEEK  = 3'd3,
    K_CLEAR = 3'd4,
    K_NOP   = 3'd5
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [LEN_W-1:0]   len;
    logic [BYTE_W-1:0]  data;
  } cmd_t;

endpackage

// File: src/length_prefixed_byte_ring_queue.sv
// Start writes the header bytes one at a time, then answers. Pop and peek read
// the header and then each data byte in turn through the single registered read
// port of the ring memory; a byte waits while the last result is not popped.
// A 2-entry command queue lets new transactions arrive while one is running.
// Reset (synchronous, rst_n low) empties both queues and sets the ring empty;
// ring contents are not cleared and no clearing pass runs.
module length_prefixed_byte_ring_queue #(
  parameter int QUEUE_BYTES  = lbrq_pkg::QUEUE_BYTES_DEF,
  parameter int HEADER_BYTES = lbrq_pkg::HEADER_BYTES_DEF,
  parameter int MAX_READ     = lbrq_pkg::MAX_READ_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [lbrq_pkg::OP_W-1:0]   in_operation,
  input  logic [lbrq_pkg::LEN_W-1:0]  in_record_length,
  input  logic [lbrq_pkg::BYTE_W-1:0] in_data_byte,
  output logic                        empty,
  input  logic                        pop,
  output logic [lbrq_pkg::STAT_W-1:0] out_status,
  output logic [lbrq_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_valid,
  output logic                        out_last,
  output logic [lbrq_pkg::LEN_W-1:0]  out_stored_length,
  output logic [lbrq_pkg::FREE_W-1:0] out_free_space
);
  import lbrq_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  lbrq_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (push),
    .in_operation     (in_operation),
    .in_record_length (in_record_length),
    .in_data_byte     (in_data_byte),
    .full             (full),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_take         (cmd_take)
  );

  lbrq_back #(
    .QUEUE_BYTES  (QUEUE_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_READ     (MAX_READ)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_take          (cmd_take),
    .empty             (empty),
    .pop               (pop),
    .out_status        (out_status),
    .out_byte          (out_byte),
    .out_valid         (out_valid),
    .out_last          (out_last),
    .out_stored_length (out_stored_length),
    .out_free_space    (out_free_space)
  );

endmodule

// File: src/lbrq_ram.sv
module lbrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port, registered read port that holds when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/lbrq_front.sv
module lbrq_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  logic [lbrq_pkg::OP_W-1:0]   in_operation,
  input  logic [lbrq_pkg::LEN_W-1:0]  in_record_length,
  input  logic [lbrq_pkg::BYTE_W-1:0] in_data_byte,
  output logic                       full,
  output logic                       cmd_valid,
  output lbrq_pkg::cmd_t             cmd,
  input  logic                       cmd_take
);
  import lbrq_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_kind_t  kind;
  logic       put;
  logic       get;

  // Classify the operation code
  always_comb begin
    case (in_operation)
      OPC_START: kind = K_START;
      OPC_PUSH:  kind = K_PUSH;
      OPC_POP:   kind = K_POP;
      OPC_PEEK:  kind = K_PEEK;
      OPC_CLEAR: kind = K_CLEAR;
      default:   kind = K_NOP;
    endcase
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = slot_r[rd_ptr_r];
  assign put       = in_push && !full;
  assign get       = cmd_valid && cmd_take;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = put ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = get ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, put} - {1'b0, get};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the classified transaction
  always_ff @(posedge clk) begin
    if (put) begin
      slot_r[wr_ptr_r] <= '{kind: kind, len: in_record_length, data: in_data_byte};
    end
  end

endmodule

// File: src/lbrq_back.sv
module lbrq_back #(
  parameter int QUEUE_BYTES  = lbrq_pkg::QUEUE_BYTES_DEF,
  parameter int HEADER_BYTES = lbrq_pkg::HEADER_BYTES_DEF,
  parameter int MAX_READ     = lbrq_pkg::MAX_READ_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  input  lbrq_pkg::cmd_t              cmd,
  output logic                        cmd_take,
  output logic                        empty,
  input  logic                        pop,
  output logic [lbrq_pkg::STAT_W-1:0] out_status,
  output logic [lbrq_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_valid,
  output logic                        out_last,
  output logic [lbrq_pkg::LEN_W-1:0]  out_stored_length,
  output logic [lbrq_pkg::FREE_W-1:0] out_free_space
);
  import lbrq_pkg::*;

  localparam int PW  = $clog2(QUEUE_BYTES);
  localparam int FW  = PW + 1;
  localparam int HCW = $clog2(HEADER_BYTES + 1);
  localparam int NW  = $clog2(MAX_READ + 1);
  localparam int AW  = 8 * HEADER_BYTES;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_WR_HDR   = 8'b0000_0010,
    S_HDR_ISS  = 8'b0000_0100,
    S_HDR_CAP  = 8'b0000_1000,
    S_HDR_DONE = 8'b0001_0000,
    S_DAT_ISS  = 8'b0010_0000,
    S_DAT_WAIT = 8'b0100_0000,
    S_EMIT     = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [FW-1:0]     free_r, free_nxt;
  logic [PW-1:0]     front_r, front_nxt;
  logic [PW-1:0]     back_r, back_nxt;
  logic [LEN_W-1:0]  pend_r, pend_nxt;
  logic [HCW-1:0]    hc_r, hc_nxt;
  logic [AW-1:0]     acc_r, acc_nxt;
  logic [PW-1:0]     dpos_r, dpos_nxt;
  logic [NW-1:0]     di_r, di_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  cmd_kind_t         kind_r, kind_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [STAT_W-1:0] res_st_r, res_st_nxt;
  logic [FW-1:0]     slen_r, slen_nxt;

  logic              out_full_r;
  logic [STAT_W-1:0] o_st_r;
  logic [BYTE_W-1:0] o_byte_r;
  logic              o_vld_r;
  logic              o_last_r;
  logic [FW-1:0]     o_slen_r;
  logic [FW-1:0]     o_free_r;

  logic              can_emit;
  logic              emit;
  logic [STAT_W-1:0] e_st;
  logic [BYTE_W-1:0] e_byte;
  logic              e_vld;
  logic              e_last;
  logic [FW-1:0]     e_slen;

  logic              ram_we;
  logic [PW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [PW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  logic [63:0]       len_sh;
  logic [FW-1:0]     slen_w;
  logic [31:0]       nf;
  logic [31:0]       cnt_min;
  logic [31:0]       slen_ext;
  logic [31:0]       free_ext;

  // Add an offset of at most one ring length to a position
  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] pos,
                                             input logic [FW-1:0] off);
    logic [FW:0] s;
    s = (FW+1)'(pos) + (FW+1)'(off);
    if (s >= (FW+1)'(QUEUE_BYTES)) begin
      s = s - (FW+1)'(QUEUE_BYTES);
    end
    return s[PW-1:0];
  endfunction

  lbrq_ram #(.WIDTH(BYTE_W), .DEPTH(QUEUE_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign can_emit = !out_full_r || pop;
  assign cmd_take = (state_r == S_IDLE);

  // Clip the header value to the ring length
  always_comb begin
    if (64'(acc_r) > 64'(QUEUE_BYTES)) begin
      slen_w = FW'(QUEUE_BYTES);
    end else begin
      slen_w = acc_r[FW-1:0];
    end
  end

  assign len_sh = 64'(len_r) >> {hc_r, 3'b000};

  // Sequence the transaction
  always_comb begin
    state_nxt  = state_r;
    free_nxt   = free_r;
    front_nxt  = front_r;
    back_nxt   = back_r;
    pend_nxt   = pend_r;
    hc_nxt     = hc_r;
    acc_nxt    = acc_r;
    dpos_nxt   = dpos_r;
    di_nxt     = di_r;
    n_nxt      = n_r;
    kind_nxt   = kind_r;
    len_nxt    = len_r;
    res_st_nxt = res_st_r;
    slen_nxt   = slen_r;
    ram_we     = 1'b0;
    ram_waddr  = back_r;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = front_r;
    emit       = 1'b0;
    e_st       = ST_OK;
    e_byte     = '0;
    e_vld      = 1'b0;
    e_last     = 1'b1;
    e_slen     = '0;
    nf         = '0;
    cnt_min    = '0;
    slen_ext   = 32'(slen_w);
    free_ext   = 32'(free_r);

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          kind_nxt   = cmd.kind;
          len_nxt    = cmd.len;
          res_st_nxt = ST_OK;
          slen_nxt   = '0;
          hc_nxt     = '0;
          state_nxt  = S_EMIT;
          case (cmd.kind)
            K_START: begin
              if (pend_r != '0) begin
                res_st_nxt = ST_OPEN;
              end else if (32'(cmd.len) + 32'(HEADER_BYTES) > free_ext) begin
                res_st_nxt = ST_FULL;
              end else begin
                state_nxt = S_WR_HDR;
              end
            end
            K_PUSH: begin
              if (pend_r == '0) begin
                res_st_nxt = ST_NO_REC;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = back_r;
                ram_wdata = cmd.data;
                back_nxt  = wrap_add(back_r, FW'(1));
                pend_nxt  = pend_r - LEN_W'(1);
              end
            end
            K_POP, K_PEEK: begin
              if (pend_r != '0) begin
                res_st_nxt = ST_OPEN;
              end else if (free_r >= FW'(QUEUE_BYTES)) begin
                res_st_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_HDR_ISS;
              end
            end
            K_CLEAR: begin
              free_nxt  = FW'(QUEUE_BYTES);
              front_nxt = back_r;
              pend_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_WR_HDR: begin
        ram_we    = 1'b1;
        ram_waddr = wrap_add(back_r, FW'(hc_r));
        ram_wdata = (32'(hc_r) < 32'd4) ? len_sh[7:0] : '0;
        if (32'(hc_r) == 32'(HEADER_BYTES - 1)) begin
          free_nxt  = free_r - FW'(32'(len_r) + 32'(HEADER_BYTES));
          back_nxt  = wrap_add(back_r, FW'(HEADER_BYTES));
          pend_nxt  = len_r;
          state_nxt = S_EMIT;
        end else begin
          hc_nxt = hc_r + HCW'(1);
        end
      end

      S_HDR_ISS: begin
        ram_re    = 1'b1;
        ram_raddr = wrap_add(front_r, FW'(hc_r));
        state_nxt = S_HDR_CAP;
      end

      S_HDR_CAP: begin
        acc_nxt[8*hc_r +: 8] = ram_rdata;
        if (32'(hc_r) == 32'(HEADER_BYTES - 1)) begin
          state_nxt = S_HDR_DONE;
        end else begin
          hc_nxt    = hc_r + HCW'(1);
          state_nxt = S_HDR_ISS;
        end
      end

      S_HDR_DONE: begin
        dpos_nxt = wrap_add(front_r, FW'(HEADER_BYTES));
        slen_nxt = slen_w;
        cnt_min  = slen_ext;
        if (32'(len_r) < cnt_min) begin
          cnt_min = 32'(len_r);
        end
        if (cnt_min > 32'(MAX_READ)) begin
          cnt_min = 32'(MAX_READ);
        end
        n_nxt  = NW'(cnt_min);
        di_nxt = '0;
        if (kind_r == K_POP) begin
          nf = free_ext + 32'(HEADER_BYTES) + slen_ext;
          free_nxt = (nf > 32'(QUEUE_BYTES)) ? FW'(QUEUE_BYTES) : nf[FW-1:0];
          if (nf >= 32'(QUEUE_BYTES)) begin
            front_nxt = back_r;
          end else begin
            front_nxt = wrap_add(wrap_add(front_r, FW'(HEADER_BYTES)), slen_w);
          end
        end
        state_nxt = (cnt_min == 32'd0) ? S_EMIT : S_DAT_ISS;
      end

      S_DAT_ISS: begin
        ram_re    = 1'b1;
        ram_raddr = wrap_add(dpos_r, FW'(di_r));
        state_nxt = S_DAT_WAIT;
      end

      S_DAT_WAIT: begin
        if (can_emit) begin
          emit   = 1'b1;
          e_byte = ram_rdata;
          e_vld  = 1'b1;
          e_last = (di_r == n_r - NW'(1));
          e_slen = slen_r;
          if (e_last) begin
            state_nxt = S_IDLE;
          end else begin
            di_nxt    = di_r + NW'(1);
            state_nxt = S_DAT_ISS;
          end
        end
      end

      S_EMIT: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_st      = res_st_r;
          e_slen    = slen_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      free_r     <= FW'(QUEUE_BYTES);
      front_r    <= '0;
      back_r     <= '0;
      pend_r     <= '0;
      out_full_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      free_r  <= free_nxt;
      front_r <= front_nxt;
      back_r  <= back_nxt;
      pend_r  <= pend_nxt;
      if (emit) begin
        out_full_r <= 1'b1;
      end else if (pop) begin
        out_full_r <= 1'b0;
      end
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    hc_r     <= hc_nxt;
    acc_r    <= acc_nxt;
    dpos_r   <= dpos_nxt;
    di_r     <= di_nxt;
    n_r      <= n_nxt;
    kind_r   <= kind_nxt;
    len_r    <= len_nxt;
    res_st_r <= res_st_nxt;
    slen_r   <= slen_nxt;
    if (emit) begin
      o_st_r   <= e_st;
      o_byte_r <= e_byte;
      o_vld_r  <= e_vld;
      o_last_r <= e_last;
      o_slen_r <= e_slen;
      o_free_r <= free_r;
    end
  end

  assign empty             = !out_full_r;
  assign out_status        = o_st_r;
  assign out_byte          = o_byte_r;
  assign out_valid         = o_vld_r;
  assign out_last          = o_last_r;
  assign out_stored_length = LEN_W'(32'(o_slen_r));
  assign out_free_space    = FREE_W'(32'(o_free_r));

`ifndef SYNTH
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= FW'(QUEUE_BYTES))
    else $error("free byte count above ring size");

  a_empty_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (free_r == FW'(QUEUE_BYTES)) |-> (front_r == back_r))
    else $error("empty ring with front and back apart");

  a_open_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != '0) |-> (32'(free_r) + 32'(HEADER_BYTES) <= 32'(QUEUE_BYTES)))
    else $error("open record without reserved space");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_full_r && !pop) |=> out_full_r)
    else $error("waiting result dropped");
`endif

endmodule
